// File: hdl/cst_pkg.sv
`timescale 1ns / 1ps

package cst_pkg;

	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] DELIM_RESET = 8'd44;

	typedef enum logic [1:0] {
		MODE_PLAIN   = 2'd0,
		MODE_QUOTED  = 2'd1,
		MODE_PENDING = 2'd2,
		MODE_ERROR   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		EV_FIELD_BYTE  = 3'd0,
		EV_END_FIELD   = 3'd1,
		EV_END_ROW     = 3'd2,
		EV_BAD_QUOTE   = 3'd3,
		EV_UNTERMINATED = 3'd4,
		EV_DOC_END     = 3'd5
	} ev_t;

endpackage

// File: hdl/csv_stream_tokenizer.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tdata[7:0] byte_value, tlast final_byte
// m_axis    out        tdata[7:0] out_byte, tuser[2:0] event_res, tlast run_last
// cfg       in         cfg_wdata[7:0] delimiter, written when cfg_we is high
//
// A byte is registered in the input buffer and then moves to the event list, from which
// its events are offered. A byte that gives at most one event can be taken every cycle
// while the output is not stalled. The final byte gives up to three events, one per
// cycle while the output is ready, set by the single output event list.
// A two-entry input buffer keeps s_axis_tready a decode of its fill count, so the input
// side can take up to two more bytes while the output is stalled.
// Reset clears the parser state and sets the delimiter to a comma.

module csv_stream_tokenizer
	import cst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] byte_value
	input  logic       s_axis_tlast,  // final_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic [2:0] m_axis_tuser,  // [2:0] event_res
	output logic       m_axis_tlast   // run_last
);

	logic [7:0] delim_q;

	// Input buffer
	logic [7:0] buf_byte_q [2];
	logic       buf_fin_q  [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] buf_cnt_q;
	logic       push;
	logic       pop;

	// Parser state
	mode_t      mode_q;
	logic       cr_seen_q;
	logic       field_bytes_q;
	logic       row_fields_q;

	// Event list of the byte being delivered
	ev_t        ev_list_q [3];
	logic [7:0] byte_q;
	logic [1:0] ev_cnt_q;
	logic [1:0] ev_idx_q;

	logic [7:0] b;
	logic       fin;
	logic       skip;
	mode_t      mode_mid;
	logic       cr_mid;
	logic       fb_mid;
	logic       rf_mid;
	logic       main_v;
	ev_t        main_ev;
	logic [7:0] main_byte;
	ev_t        ev_new [3];
	logic [1:0] n_new;
	ev_t        ev_cur;
	logic       m_fire;
	logic       list_free;

	assign b    = buf_byte_q[rd_ptr_q];
	assign fin  = buf_fin_q[rd_ptr_q];
	assign skip = cr_seen_q && (b == CH_LF);

	assign s_axis_tready = (buf_cnt_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;

	assign ev_cur        = ev_list_q[ev_idx_q];
	assign m_axis_tvalid = (ev_cnt_q != 2'd0);
	assign m_axis_tuser  = ev_cur;
	assign m_axis_tdata  = (ev_cur == EV_FIELD_BYTE) ? byte_q : 8'd0;
	assign m_axis_tlast  = ((ev_idx_q + 2'd1) == ev_cnt_q);
	assign m_fire        = m_axis_tvalid && m_axis_tready;
	assign list_free     = (ev_cnt_q == 2'd0) || (m_fire && m_axis_tlast);
	assign pop           = (buf_cnt_q != 2'd0) && list_free;

	// Next parser state for the byte at the head of the buffer
	always_comb begin
		mode_mid = mode_q;
		cr_mid   = 1'b0;
		fb_mid   = field_bytes_q;
		rf_mid   = row_fields_q;
		unique case (mode_q)
			MODE_QUOTED: begin
				if (b == CH_QUOTE) begin
					mode_mid = MODE_PENDING;
				end else begin
					fb_mid = 1'b1;
				end
			end
			MODE_PENDING: begin
				if (b == CH_QUOTE) begin
					fb_mid   = 1'b1;
					mode_mid = MODE_QUOTED;
				end else begin
					mode_mid = MODE_PLAIN;
					if (b == delim_q) begin
						fb_mid = 1'b0;
						rf_mid = 1'b1;
					end else if (b == CH_CR || b == CH_LF) begin
						fb_mid = 1'b0;
						rf_mid = 1'b0;
						cr_mid = (b == CH_CR);
					end else begin
						mode_mid = MODE_ERROR;
					end
				end
			end
			MODE_PLAIN: begin
				if (skip) begin
					// The LF of a CR LF pair is swallowed.
				end else if (b == CH_QUOTE && !field_bytes_q) begin
					mode_mid = MODE_QUOTED;
				end else if (b == delim_q) begin
					fb_mid = 1'b0;
					rf_mid = 1'b1;
				end else if (b == CH_CR || b == CH_LF) begin
					fb_mid = 1'b0;
					rf_mid = 1'b0;
					cr_mid = (b == CH_CR);
				end else begin
					fb_mid = 1'b1;
				end
			end
			MODE_ERROR: begin
			end
			default: begin
			end
		endcase
	end

	// Events caused by the byte at the head of the buffer
	always_comb begin
		main_v    = 1'b0;
		main_ev   = EV_FIELD_BYTE;
		main_byte = 8'd0;
		unique case (mode_q)
			MODE_QUOTED: begin
				if (b != CH_QUOTE) begin
					main_v    = 1'b1;
					main_byte = b;
				end
			end
			MODE_PENDING: begin
				main_v = 1'b1;
				if (b == CH_QUOTE) begin
					main_byte = CH_QUOTE;
				end else if (b == delim_q) begin
					main_ev = EV_END_FIELD;
				end else if (b == CH_CR || b == CH_LF) begin
					main_ev = EV_END_ROW;
				end else begin
					main_ev = EV_BAD_QUOTE;
				end
			end
			MODE_PLAIN: begin
				if (skip) begin
				end else if (b == CH_QUOTE && !field_bytes_q) begin
				end else if (b == delim_q) begin
					main_v  = 1'b1;
					main_ev = EV_END_FIELD;
				end else if (b == CH_CR || b == CH_LF) begin
					main_v  = 1'b1;
					main_ev = EV_END_ROW;
				end else begin
					main_v    = 1'b1;
					main_byte = b;
				end
			end
			MODE_ERROR: begin
			end
			default: begin
			end
		endcase

		ev_new[0] = EV_FIELD_BYTE;
		ev_new[1] = EV_FIELD_BYTE;
		ev_new[2] = EV_FIELD_BYTE;
		n_new     = 2'd0;
		if (main_v) begin
			ev_new[n_new] = main_ev;
			n_new         = n_new + 2'd1;
		end
		if (fin) begin
			if (mode_mid == MODE_QUOTED) begin
				ev_new[n_new] = EV_UNTERMINATED;
				n_new         = n_new + 2'd1;
			end else if (mode_mid != MODE_ERROR &&
			             (fb_mid || rf_mid || b == delim_q)) begin
				ev_new[n_new] = EV_END_ROW;
				n_new         = n_new + 2'd1;
			end
			ev_new[n_new] = EV_DOC_END;
			n_new         = n_new + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (cfg_we) begin
			delim_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_byte_q[wr_ptr_q] <= s_axis_tdata;
			buf_fin_q[wr_ptr_q]  <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
			buf_cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			buf_cnt_q <= buf_cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_PLAIN;
			cr_seen_q     <= 1'b0;
			field_bytes_q <= 1'b0;
			row_fields_q  <= 1'b0;
		end else if (pop) begin
			if (fin) begin
				mode_q        <= MODE_PLAIN;
				cr_seen_q     <= 1'b0;
				field_bytes_q <= 1'b0;
				row_fields_q  <= 1'b0;
			end else begin
				mode_q        <= mode_mid;
				cr_seen_q     <= cr_mid;
				field_bytes_q <= fb_mid;
				row_fields_q  <= rf_mid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_list_q[0] <= ev_new[0];
			ev_list_q[1] <= ev_new[1];
			ev_list_q[2] <= ev_new[2];
			byte_q       <= main_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_cnt_q <= 2'd0;
			ev_idx_q <= 2'd0;
		end else if (pop) begin
			ev_cnt_q <= n_new;
			ev_idx_q <= 2'd0;
		end else if (m_fire) begin
			if (m_axis_tlast) begin
				ev_cnt_q <= 2'd0;
				ev_idx_q <= 2'd0;
			end else begin
				ev_idx_q <= ev_idx_q + 2'd1;
			end
		end
	end

endmodule

// File: hdl/cst_checker.sv
`timescale 1ns / 1ps

module cst_checker
	import cst_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [2:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	// A stalled result request must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
		$stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= EV_DOC_END)
		else $error("event code out of range");

	// Only field bytes carry data.
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != EV_FIELD_BYTE |-> m_axis_tdata == 8'd0)
		else $error("non-byte event carries data");

	// Document end is always the closing event of its byte.
	a_doc_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == EV_DOC_END |-> m_axis_tlast)
		else $error("document end not last event");

	// An unterminated quote report is followed directly by document end.
	a_unterm_then_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser == EV_UNTERMINATED |->
		!m_axis_tlast ##1 (m_axis_tvalid && m_axis_tuser == EV_DOC_END))
		else $error("unterminated quote not followed by document end");

endmodule

bind csv_stream_tokenizer cst_checker u_cst_checker (.*);

// File: test/csv_stream_tokenizer_tb.sv
`timescale 1ns / 1ps

module csv_stream_tokenizer_tb;
	import cst_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       fin;
	} doc_byte_t;

	typedef struct {
		ev_t        ev;
		logic [7:0] value;
		logic       last;
	} token_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;  // [7:0] byte_value
	logic       s_axis_tlast = 1'b0;   // final_byte
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;          // [7:0] out_byte
	logic [2:0] m_axis_tuser;          // [2:0] event_res
	logic       m_axis_tlast;          // run_last

	doc_byte_t  pending_bytes[$];
	token_t     expected_tokens[$];
	token_t     step_tokens[$];
	int         queued_bytes = 0;
	int         errors = 0;
	int         send_gap = 0;
	int         recv_stall = 0;
	logic       steady = 1'b0;
	logic       hold_on = 1'b0;

	// Tokeniser state as the testbench sees it.
	mode_t      scan_mode = MODE_PLAIN;
	logic       cr_seen = 1'b0;
	logic       field_has_bytes = 1'b0;
	logic       row_has_fields = 1'b0;
	logic [7:0] delim_model = DELIM_RESET;

	csv_stream_tokenizer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void add_token(ev_t ev, logic [7:0] value);
		token_t t;
		t.ev = ev;
		t.value = (ev == EV_FIELD_BYTE) ? value : 8'h00;
		t.last = 1'b0;
		step_tokens = {step_tokens, t};
	endfunction

	function automatic void close_field();
		add_token(EV_END_FIELD, 8'h00);
		field_has_bytes = 1'b0;
		row_has_fields = 1'b1;
	endfunction

	function automatic void close_row(logic [7:0] b);
		add_token(EV_END_ROW, 8'h00);
		field_has_bytes = 1'b0;
		row_has_fields = 1'b0;
		cr_seen = (b == CH_CR);
	endfunction

	// Works out the events that one accepted byte gives and queues them.
	function automatic void tokenize_byte(logic [7:0] b, logic fin);
		logic lf_of_crlf;
		lf_of_crlf = cr_seen && (b == CH_LF);
		cr_seen = 1'b0;
		step_tokens.delete();
		case (scan_mode)
			MODE_QUOTED: begin
				if (b == CH_QUOTE) begin
					scan_mode = MODE_PENDING;
				end else begin
					add_token(EV_FIELD_BYTE, b);
					field_has_bytes = 1'b1;
				end
			end
			MODE_PENDING: begin
				if (b == CH_QUOTE) begin
					add_token(EV_FIELD_BYTE, CH_QUOTE);
					field_has_bytes = 1'b1;
					scan_mode = MODE_QUOTED;
				end else begin
					scan_mode = MODE_PLAIN;
					if (b == delim_model) begin
						close_field();
					end else if (b == CH_CR || b == CH_LF) begin
						close_row(b);
					end else begin
						add_token(EV_BAD_QUOTE, 8'h00);
						scan_mode = MODE_ERROR;
					end
				end
			end
			MODE_PLAIN: begin
				if (lf_of_crlf) begin
					// The LF of a CR LF pair is swallowed.
				end else if (b == CH_QUOTE && !field_has_bytes) begin
					scan_mode = MODE_QUOTED;
				end else if (b == delim_model) begin
					close_field();
				end else if (b == CH_CR || b == CH_LF) begin
					close_row(b);
				end else begin
					add_token(EV_FIELD_BYTE, b);
					field_has_bytes = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (fin) begin
			if (scan_mode == MODE_QUOTED) begin
				add_token(EV_UNTERMINATED, 8'h00);
			end else if (scan_mode != MODE_ERROR &&
					(field_has_bytes || row_has_fields || b == delim_model)) begin
				add_token(EV_END_ROW, 8'h00);
			end
			add_token(EV_DOC_END, 8'h00);
			scan_mode = MODE_PLAIN;
			cr_seen = 1'b0;
			field_has_bytes = 1'b0;
			row_has_fields = 1'b0;
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i])
			expected_tokens = {expected_tokens, step_tokens[i]};
	endfunction

	function automatic int next_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// Sender: offers the queued bytes, with random gaps between requests.
	always @(posedge clk or negedge arst_n) begin : drive_bytes
		doc_byte_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
			s_axis_tlast <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				tokenize_byte(s_axis_tdata, s_axis_tlast);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap == 0 && pending_bytes.size() > 0) begin
					nxt = pending_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= nxt.value;
					s_axis_tlast <= nxt.fin;
					send_gap <= next_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
					if (send_gap > 0)
						send_gap <= send_gap - 1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall <= 0;
		end else if (hold_on) begin
			m_axis_tready <= 1'b0;
		end else if (recv_stall > 0) begin
			m_axis_tready <= 1'b0;
			recv_stall <= recv_stall - 1;
		end else begin
			m_axis_tready <= 1'b1;
			recv_stall <= next_gap();
		end
	end

	always @(posedge clk) begin : check_events
		token_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected result: event_res %0d out_byte %02h run_last %0b",
					m_axis_tuser, m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				want = expected_tokens.pop_front();
				if (m_axis_tuser !== want.ev) begin
					$error("event_res: expected %0d, got %0d", want.ev, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata !== want.value) begin
					$error("out_byte: expected %02h, got %02h", want.value, m_axis_tdata);
					errors++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("run_last: expected %0b, got %0b", want.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	function automatic void add_byte(logic [7:0] value, logic fin = 1'b0);
		doc_byte_t d;
		d.value = value;
		d.fin = fin;
		pending_bytes = {pending_bytes, d};
		queued_bytes++;
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		if ($urandom_range(0, 1))
			c = 8'($urandom_range(8'h61, 8'h7A));
		else
			c = 8'($urandom_range(0, 255));
		if (c == CH_QUOTE || c == CH_CR || c == CH_LF || c == delim_model)
			c = 8'h5F;
		return c;
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 5))
			0: return CH_QUOTE;
			1: return CH_CR;
			2: return CH_LF;
			3: return delim_model;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Queues one document, mostly well formed, ending with the final byte.
	function automatic void queue_document();
		int rows;
		int fields;
		int kind;
		int len;
		int start;
		start = queued_bytes;
		if ($urandom_range(0, 9) == 0) begin
			len = $urandom_range(1, 6);
			repeat (len) add_byte(noise_byte());
		end else begin
			rows = $urandom_range(1, 3);
			for (int r = 0; r < rows; r++) begin
				fields = $urandom_range(1, 3);
				for (int f = 0; f < fields; f++) begin
					if (f != 0)
						add_byte(delim_model);
					kind = $urandom_range(0, 9);
					len = $urandom_range(0, 3);
					if (kind < 6) begin
						repeat (len) add_byte(plain_char());
					end else begin
						add_byte(CH_QUOTE);
						repeat (len) begin
							if ($urandom_range(0, 4) == 0) begin
								add_byte(CH_QUOTE);
								add_byte(CH_QUOTE);
							end else begin
								add_byte(noise_byte() == CH_QUOTE ? 8'h27 : 8'($urandom_range(0, 255)));
							end
						end
						add_byte(CH_QUOTE);
						// A stray character after the closing quote.
						if (kind == 9)
							add_byte(plain_char());
					end
				end
				if (r < rows - 1 || $urandom_range(0, 1)) begin
					case ($urandom_range(0, 2))
						0: add_byte(CH_CR);
						1: add_byte(CH_LF);
						default: begin
							add_byte(CH_CR);
							add_byte(CH_LF);
						end
					endcase
				end
			end
		end
		if (queued_bytes == start)
			add_byte(plain_char());
		pending_bytes[pending_bytes.size() - 1].fin = 1'b1;
	endfunction

	function automatic void queue_documents(int count);
		int target;
		target = queued_bytes + count;
		while (queued_bytes < target)
			queue_document();
	endfunction

	// Waits until every request has been taken and every result has come back.
	task automatic settle();
		int guard;
		guard = 0;
		while (pending_bytes.size() != 0 || s_axis_tvalid)
			@(negedge clk);
		while (expected_tokens.size() != 0 && guard < 4000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic set_delimiter(logic [7:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		delim_model = value;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Quoted field with a doubled quote, then CR LF.
		add_byte("a"); add_byte(","); add_byte(CH_QUOTE); add_byte("b");
		add_byte(CH_QUOTE); add_byte(CH_QUOTE); add_byte("c"); add_byte(CH_QUOTE);
		add_byte(CH_CR); add_byte(CH_LF);
		// Quote within a field that has bytes, lone CR and lone LF.
		add_byte("d"); add_byte(CH_QUOTE); add_byte(CH_CR); add_byte("e"); add_byte(CH_LF);
		// Stray byte after a closing quote, then ignored bytes up to the end.
		add_byte(CH_QUOTE); add_byte("x"); add_byte(CH_QUOTE); add_byte("y");
		add_byte(8'hFF, 1'b1);
		// Extreme bytes, and a final byte that is the delimiter.
		add_byte(8'h00); add_byte(8'hFF); add_byte(",", 1'b1);
		// Unterminated quote.
		add_byte(CH_QUOTE); add_byte("q", 1'b1);
		// Final byte that closes a quoted field.
		add_byte(CH_QUOTE); add_byte("z"); add_byte(CH_QUOTE, 1'b1);
		queue_documents(28);
		settle();

		set_delimiter(8'd1);
		queue_documents(20);
		settle();

		steady = 1'b1;
		set_delimiter(8'd255);
		queue_documents(20);
		settle();
		steady = 1'b0;

		set_delimiter(CH_QUOTE);
		queue_documents(14);
		settle();

		set_delimiter(CH_CR);
		queue_documents(10);
		settle();

		set_delimiter(CH_LF);
		queue_documents(10);
		settle();

		set_delimiter(8'h09);
		queue_documents(14);
		settle();

		// The receiver holds off while the sender keeps requesting, so the
		// block fills up and drops s_axis_tready.
		steady = 1'b1;
		set_delimiter(DELIM_RESET);
		queue_documents(28);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (60) @(posedge clk);
		hold_on <= 1'b0;
		settle();

		if (expected_tokens.size() != 0) begin
			$error("%0d expected results never arrived", expected_tokens.size());
			errors++;
		end
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: csv_stream_tokenizer.f
hdl/cst_pkg.sv
hdl/csv_stream_tokenizer.sv
hdl/cst_checker.sv
test/csv_stream_tokenizer_tb.sv
